// File: rtl/dlle_pkg.sv
// shared constants of the doubly linked list engine: field widths, opcodes, status codes
// no dependencies
package dlle_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 3;
	localparam int POS_W  = 6;
	localparam int STAT_W = 2;

	// opcodes
	localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_HEAD  = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_TAIL  = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
	localparam logic [OP_W-1:0] OP_DISPLAY   = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

endpackage

// File: rtl/dlle_ram.sv
// generic single-write, single-read ram with a registered read port
// no dependencies
module dlle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/doubly_linked_list_engine_core.sv
// top level of the doubly linked list engine: command port, sequencer, node memory
// depends on dlle_pkg and dlle_ram
//
// Bounded doubly linked list of signed 32-bit values. Pulse start with an opcode while busy
// is low; the command is taken on that edge and busy rises until its work is done (it stays
// low for rejected and ignored commands). Every result beat shows on status/element/last,
// flagged by result_strobe for exactly one cycle; there is no way to hold results off, so
// the receiver must take each beat as it comes. Inserts and deletes answer with one beat
// (last set). Display answers with one beat per element from head to tail, the final one
// marked by last; an empty list answers with a single empty-status beat. Opcode seven is
// taken and ignored. Rejected commands (full, empty, bad position) answer with one beat.
// The next command can be taken at the edge that takes the final beat. Positions are
// reached by walking the list: each hop is one read of the node memory, one hop per cycle.
// All node state (value, next and prev links) lives in a single synchronous node memory;
// head, tail, free-list head, element count and a fill mark live in flops. Nodes never used
// yet are handed out from the fill mark, so the memory needs no clearing pass after reset
// and commands are taken right out of reset.
module doubly_linked_list_engine_core #(
	parameter int CAPACITY = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// command beat
	input  logic                                   start,
	output logic                                   busy,
	input  logic [dlle_pkg::OP_W-1:0]              opcode,
	input  logic signed [dlle_pkg::DATA_W-1:0]     value,
	input  logic [dlle_pkg::POS_W-1:0]             position,
	// result beat
	output logic                                   result_strobe,
	output logic [dlle_pkg::STAT_W-1:0]            status,
	output logic signed [dlle_pkg::DATA_W-1:0]     element,
	output logic                                   last
);

	// link width holds 0..CAPACITY, the top code being the null link
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = (LW > dlle_pkg::POS_W) ? LW : dlle_pkg::POS_W;
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	// one node memory entry
	typedef struct packed {
		logic [LW-1:0]                     prv;
		logic [LW-1:0]                     nxt;
		logic signed [dlle_pkg::DATA_W-1:0] val;
	} node_t;

	// pending read-modify-write of one link field
	typedef struct packed {
		logic          vld;
		logic          fld_prv;
		logic [LW-1:0] addr;
		logic [LW-1:0] data;
	} patch_t;

	typedef enum logic [11:0] {
		IDLE     = 12'b0000_0000_0001,
		WALK_RD  = 12'b0000_0000_0010,
		WALK_DT  = 12'b0000_0000_0100,
		ALLOC_RD = 12'b0000_0000_1000,
		ALLOC_DT = 12'b0000_0001_0000,
		WR_NEW   = 12'b0000_0010_0000,
		WR_T     = 12'b0000_0100_0000,
		FREE_WR  = 12'b0000_1000_0000,
		PATCH_RD = 12'b0001_0000_0000,
		PATCH_WR = 12'b0010_0000_0000,
		DISP_RD  = 12'b0100_0000_0000,
		DISP_DT  = 12'b1000_0000_0000
	} state_t;

	state_t                             state_q;
	logic [dlle_pkg::OP_W-1:0]          op_q;
	logic signed [dlle_pkg::DATA_W-1:0] val_q;
	logic [LW-1:0]                      head_q;
	logic [LW-1:0]                      tail_q;
	logic [LW-1:0]                      fh_q;     // free-list head of recycled nodes
	logic [LW-1:0]                      cnt_q;
	logic [LW-1:0]                      hw_q;     // fill mark: nodes at or above never used
	logic [LW-1:0]                      n_q;      // new node
	logic [LW-1:0]                      t_q;      // target node
	node_t                              te_q;     // target node entry
	logic [LW-1:0]                      cur_q;
	logic [dlle_pkg::POS_W-1:0]         rem_q;
	patch_t                             pa_q;
	patch_t                             pb_q;
	logic                               strobe_q;
	logic [dlle_pkg::STAT_W-1:0]        status_q;
	logic signed [dlle_pkg::DATA_W-1:0] element_q;
	logic                               last_q;

	// node memory ports
	logic          ram_we;
	logic [LW-1:0] ram_waddr;
	node_t         ram_wdata;
	logic [LW-1:0] ram_raddr;
	node_t         rd_node;

	logic accept;
	logic full;
	logic empty;
	logic pos_bad;

	assign accept  = start && (state_q == IDLE);
	assign full    = (cnt_q == NIL);
	assign empty   = (cnt_q == '0);
	// position zero, or past the end of the list
	assign pos_bad = (position == '0) || (PW'(position) > PW'(cnt_q));

	assign busy          = (state_q != IDLE);
	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign element       = element_q;
	assign last          = last_q;

	dlle_ram #(
		.WIDTH($bits(node_t)),
		.DEPTH(CAPACITY)
	) u_node_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(ram_raddr[AW-1:0]),
		.rdata(rd_node)
	);

	// read address: walks hop straight from the returned next link
	always_comb begin
		case (state_q)
			WALK_RD:  ram_raddr = cur_q;
			WALK_DT:  ram_raddr = rd_node.nxt;
			ALLOC_RD: ram_raddr = fh_q;
			PATCH_RD: ram_raddr = pa_q.addr;
			DISP_RD:  ram_raddr = cur_q;
			DISP_DT:  ram_raddr = rd_node.nxt;
			default:  ram_raddr = cur_q;
		endcase
	end

	// write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = t_q;
		ram_wdata = te_q;
		case (state_q)
			WR_NEW: begin
				ram_we        = 1'b1;
				ram_waddr     = n_q;
				ram_wdata.val = val_q;
				case (op_q)
					dlle_pkg::OP_INS_HEAD: begin
						ram_wdata.prv = NIL;
						ram_wdata.nxt = head_q;
					end
					dlle_pkg::OP_INS_TAIL: begin
						ram_wdata.prv = tail_q;
						ram_wdata.nxt = NIL;
					end
					default: begin
						ram_wdata.prv = t_q;
						ram_wdata.nxt = te_q.nxt;
					end
				endcase
			end
			WR_T: begin
				// target now points forward to the new node
				ram_we        = 1'b1;
				ram_wdata.nxt = n_q;
			end
			FREE_WR: begin
				// freed node joins the front of the free list
				ram_we        = 1'b1;
				ram_wdata.nxt = fh_q;
			end
			PATCH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pa_q.addr;
				ram_wdata = rd_node;
				if (pa_q.fld_prv) begin
					ram_wdata.prv = pa_q.data;
				end else begin
					ram_wdata.nxt = pa_q.data;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			op_q      <= '0;
			val_q     <= '0;
			head_q    <= NIL;
			tail_q    <= NIL;
			fh_q      <= NIL;
			cnt_q     <= '0;
			hw_q      <= '0;
			n_q       <= '0;
			t_q       <= '0;
			te_q      <= '0;
			cur_q     <= '0;
			rem_q     <= '0;
			pa_q      <= '0;
			pb_q      <= '0;
			strobe_q  <= 1'b0;
			status_q  <= dlle_pkg::ST_OK;
			element_q <= '0;
			last_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept) begin
						op_q  <= opcode;
						val_q <= value;
						rem_q <= position - 1'b1;
						cur_q <= head_q;
						// default answer for rejected commands
						status_q  <= dlle_pkg::ST_OK;
						element_q <= '0;
						last_q    <= 1'b1;
						case (opcode)
							dlle_pkg::OP_INS_HEAD, dlle_pkg::OP_INS_TAIL: begin
								if (full) begin
									strobe_q <= 1'b1;
									status_q <= dlle_pkg::ST_FULL;
								end else begin
									state_q <= ALLOC_RD;
								end
							end
							dlle_pkg::OP_INS_AFTER: begin
								if (pos_bad) begin
									strobe_q <= 1'b1;
									status_q <= dlle_pkg::ST_RANGE;
								end else if (full) begin
									strobe_q <= 1'b1;
									status_q <= dlle_pkg::ST_FULL;
								end else begin
									state_q <= WALK_RD;
								end
							end
							dlle_pkg::OP_DEL_HEAD, dlle_pkg::OP_DEL_TAIL: begin
								rem_q <= '0;
								if (opcode == dlle_pkg::OP_DEL_TAIL) begin
									cur_q <= tail_q;
								end
								if (empty) begin
									strobe_q <= 1'b1;
									status_q <= dlle_pkg::ST_EMPTY;
								end else begin
									state_q <= WALK_RD;
								end
							end
							dlle_pkg::OP_DEL_AT: begin
								if (pos_bad) begin
									strobe_q <= 1'b1;
									status_q <= dlle_pkg::ST_RANGE;
								end else begin
									state_q <= WALK_RD;
								end
							end
							dlle_pkg::OP_DISPLAY: begin
								if (empty) begin
									strobe_q <= 1'b1;
									status_q <= dlle_pkg::ST_EMPTY;
								end else begin
									state_q <= DISP_RD;
								end
							end
							default: begin
								state_q <= IDLE;
							end
						endcase
					end
				end
				WALK_RD: begin
					state_q <= WALK_DT;
				end
				WALK_DT: begin
					if (rem_q != '0) begin
						// hop: next read already issued from this entry
						cur_q <= rd_node.nxt;
						rem_q <= rem_q - 1'b1;
					end else begin
						t_q  <= cur_q;
						te_q <= rd_node;
						if (op_q == dlle_pkg::OP_INS_AFTER) begin
							state_q <= ALLOC_RD;
						end else begin
							// unlink: fix the neighbors or the end pointers
							if (rd_node.prv != NIL) begin
								pa_q <= '{vld: 1'b1, fld_prv: 1'b0,
									addr: rd_node.prv, data: rd_node.nxt};
							end else begin
								pa_q.vld <= 1'b0;
								head_q   <= rd_node.nxt;
							end
							if (rd_node.nxt != NIL) begin
								pb_q <= '{vld: 1'b1, fld_prv: 1'b1,
									addr: rd_node.nxt, data: rd_node.prv};
							end else begin
								pb_q.vld <= 1'b0;
								tail_q   <= rd_node.prv;
							end
							state_q <= FREE_WR;
						end
					end
				end
				ALLOC_RD: begin
					if (fh_q != NIL) begin
						state_q <= ALLOC_DT;
					end else begin
						n_q     <= hw_q;
						hw_q    <= hw_q + 1'b1;
						state_q <= WR_NEW;
					end
				end
				ALLOC_DT: begin
					n_q     <= fh_q;
					fh_q    <= rd_node.nxt;
					state_q <= WR_NEW;
				end
				WR_NEW: begin
					cnt_q    <= cnt_q + 1'b1;
					pb_q.vld <= 1'b0;
					case (op_q)
						dlle_pkg::OP_INS_HEAD: begin
							if (head_q != NIL) begin
								pa_q <= '{vld: 1'b1, fld_prv: 1'b1, addr: head_q, data: n_q};
							end else begin
								pa_q.vld <= 1'b0;
								tail_q   <= n_q;
							end
							head_q  <= n_q;
							state_q <= PATCH_RD;
						end
						dlle_pkg::OP_INS_TAIL: begin
							if (tail_q != NIL) begin
								pa_q <= '{vld: 1'b1, fld_prv: 1'b0, addr: tail_q, data: n_q};
							end else begin
								pa_q.vld <= 1'b0;
								head_q   <= n_q;
							end
							tail_q  <= n_q;
							state_q <= PATCH_RD;
						end
						default: begin
							if (te_q.nxt != NIL) begin
								pa_q <= '{vld: 1'b1, fld_prv: 1'b1, addr: te_q.nxt, data: n_q};
							end else begin
								pa_q.vld <= 1'b0;
								tail_q   <= n_q;
							end
							state_q <= WR_T;
						end
					endcase
				end
				WR_T: begin
					state_q <= PATCH_RD;
				end
				FREE_WR: begin
					fh_q    <= t_q;
					cnt_q   <= cnt_q - 1'b1;
					state_q <= PATCH_RD;
				end
				PATCH_RD: begin
					if (pa_q.vld) begin
						state_q <= PATCH_WR;
					end else if (pb_q.vld) begin
						// only the second link needs fixing, move it up
						pa_q     <= pb_q;
						pb_q.vld <= 1'b0;
					end else begin
						// all links settled
						strobe_q  <= 1'b1;
						status_q  <= dlle_pkg::ST_OK;
						element_q <= '0;
						last_q    <= 1'b1;
						state_q   <= IDLE;
					end
				end
				PATCH_WR: begin
					pa_q     <= pb_q;
					pb_q.vld <= 1'b0;
					state_q  <= PATCH_RD;
				end
				DISP_RD: begin
					state_q <= DISP_DT;
				end
				DISP_DT: begin
					// one beat per element, next read issued from this entry
					strobe_q  <= 1'b1;
					status_q  <= dlle_pkg::ST_OK;
					element_q <= rd_node.val;
					last_q    <= (rd_node.nxt == NIL);
					if (rd_node.nxt == NIL) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/sv/dlle_list_checker.sv
`timescale 1ns / 100ps
// list checker: watches the command and result beats, mirrors the linked list and compares
// depends on dlle_pkg
module dlle_list_checker #(
	parameter int CAPACITY = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [dlle_pkg::OP_W-1:0]          opcode,
	input  logic signed [dlle_pkg::DATA_W-1:0] value,
	input  logic [dlle_pkg::POS_W-1:0]         position,
	input  logic                               result_strobe,
	input  logic [dlle_pkg::STAT_W-1:0]        status,
	input  logic signed [dlle_pkg::DATA_W-1:0] element,
	input  logic                               last,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 beats_seen,
	output int                                 cmds_seen
);
	import dlle_pkg::*;

	localparam int LINK_W = $clog2(CAPACITY + 1);
	localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);
	localparam int MAX_PRINTED = 30;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} beat_t;

	beat_t expected_beats[$];
	beat_t oldest;

	// mirror of the list
	logic signed [DATA_W-1:0] node_val [0:CAPACITY];
	logic [LINK_W-1:0]        nxt [0:CAPACITY];
	logic [LINK_W-1:0]        prv [0:CAPACITY];
	logic [LINK_W-1:0]        head_idx, tail_idx, free_idx, count;

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	task automatic push_beat(input logic [STAT_W-1:0] st, input logic signed [DATA_W-1:0] el,
			input logic lst);
		beat_t b;
		b.status = st;
		b.element = el;
		b.last = lst;
		expected_beats.push_back(b);
	endtask

	task automatic take_node(input logic signed [DATA_W-1:0] v, output logic [LINK_W-1:0] n);
		n = free_idx;
		free_idx = nxt[n];
		node_val[n] = v;
		count++;
	endtask

	task automatic unlink_node(input logic [LINK_W-1:0] t);
		logic [LINK_W-1:0] pv, nx;
		pv = prv[t];
		nx = nxt[t];
		if (pv != NIL) nxt[pv] = nx; else head_idx = nx;
		if (nx != NIL) prv[nx] = pv; else tail_idx = pv;
		nxt[t] = free_idx;
		free_idx = t;
		count--;
	endtask

	function automatic logic [LINK_W-1:0] node_at(input int p);
		logic [LINK_W-1:0] t;
		t = head_idx;
		for (int i = 1; i < p && t != NIL; i++)
			t = nxt[t];
		return t;
	endfunction

	// expected beats of one accepted command
	task automatic predict_list_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
			input logic [POS_W-1:0] pos);
		logic full, empty, bad_pos;
		logic [LINK_W-1:0] n, t;
		logic [STAT_W-1:0] st;
		int k;
		full = (int'(count) >= CAPACITY);
		empty = (count == 0);
		bad_pos = (pos < 1) || (int'(pos) > int'(count));
		st = ST_OK;
		case (op)
			OP_INS_HEAD: begin
				if (full) st = ST_FULL;
				else begin
					take_node(v, n);
					prv[n] = NIL;
					nxt[n] = head_idx;
					if (head_idx != NIL) prv[head_idx] = n; else tail_idx = n;
					head_idx = n;
				end
			end
			OP_INS_TAIL: begin
				if (full) st = ST_FULL;
				else begin
					take_node(v, n);
					nxt[n] = NIL;
					prv[n] = tail_idx;
					if (tail_idx != NIL) nxt[tail_idx] = n; else head_idx = n;
					tail_idx = n;
				end
			end
			OP_INS_AFTER: begin
				// range check wins over full
				if (bad_pos) st = ST_RANGE;
				else if (full) st = ST_FULL;
				else begin
					t = node_at(int'(pos));
					take_node(v, n);
					nxt[n] = nxt[t];
					prv[n] = t;
					if (nxt[t] != NIL) prv[nxt[t]] = n; else tail_idx = n;
					nxt[t] = n;
				end
			end
			OP_DEL_HEAD: begin
				if (empty) st = ST_EMPTY;
				else unlink_node(head_idx);
			end
			OP_DEL_TAIL: begin
				if (empty) st = ST_EMPTY;
				else unlink_node(tail_idx);
			end
			OP_DEL_AT: begin
				if (bad_pos) st = ST_RANGE;
				else unlink_node(node_at(int'(pos)));
			end
			OP_DISPLAY: begin
				if (empty) push_beat(ST_EMPTY, '0, 1'b1);
				else begin
					k = 0;
					t = head_idx;
					while (t != NIL && k < CAPACITY) begin
						push_beat(ST_OK, node_val[t], nxt[t] == NIL);
						t = nxt[t];
						k++;
					end
				end
				return;
			end
			default: return;
		endcase
		push_beat(st, '0, 1'b1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= CAPACITY; i++) begin
				node_val[i] = '0;
				prv[i] = NIL;
				nxt[i] = (i < CAPACITY) ? LINK_W'(i + 1) : NIL;
			end
			head_idx = NIL;
			tail_idx = NIL;
			free_idx = '0;
			count = '0;
			expected_beats.delete();
			fail_count = 0;
			pending = 0;
			beats_seen = 0;
			cmds_seen = 0;
		end else begin
			if (result_strobe) begin
				beats_seen++;
				if (expected_beats.size() == 0)
					report_mismatch($sformatf("beat with nothing expected (status %0d element %0d)",
						status, element));
				else begin
					oldest = expected_beats.pop_front();
					if (status !== oldest.status)
						report_mismatch($sformatf("beat %0d status %0d, want %0d",
							beats_seen, status, oldest.status));
					if (element !== oldest.element)
						report_mismatch($sformatf("beat %0d element %0d, want %0d",
							beats_seen, element, oldest.element));
					if (last !== oldest.last)
						report_mismatch($sformatf("beat %0d last %0b, want %0b",
							beats_seen, last, oldest.last));
				end
			end
			if (start && !busy) begin
				cmds_seen++;
				predict_list_op(opcode, value, position);
			end
			pending = expected_beats.size();
		end
	end

endmodule

// File: tb/sv/doubly_linked_list_engine_core_tb.sv
`timescale 1ns / 100ps
// testbench top of the doubly linked list engine: clock, reset, command stimulus, verdict
// depends on dlle_pkg, doubly_linked_list_engine_core and dlle_list_checker
module doubly_linked_list_engine_core_tb;
	import dlle_pkg::*;

	localparam int CAPACITY = 32;
	localparam int CYCLE_LIMIT = 400000;
	// longest command is a full display or a walk to the far end
	localparam int SETTLE_CYCLES = 64;
	localparam int ITEMS_PER_PHASE = 134;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	typedef enum {GROW, SHRINK, MIXED} burst_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [OP_W-1:0]          opcode = OP_INS_HEAD;
	logic signed [DATA_W-1:0] value = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     busy;
	logic                     result_strobe;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] element;
	logic                     last;

	int fail_count, pending, beats_seen, cmds_seen;
	int cycle_count = 0;
	int idle_pct = 0;

	doubly_linked_list_engine_core #(.CAPACITY(CAPACITY)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.value        (value),
		.position     (position),
		.result_strobe(result_strobe),
		.status       (status),
		.element      (element),
		.last         (last)
	);

	dlle_list_checker #(.CAPACITY(CAPACITY)) list_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.value        (value),
		.position     (position),
		.result_strobe(result_strobe),
		.status       (status),
		.element      (element),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending),
		.beats_seen   (beats_seen),
		.cmds_seen    (cmds_seen)
	);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d beats still expected", cycle_count, pending);
			$display("doubly_linked_list_engine_core regression: fail");
			$finish;
		end
	end

	// one command beat: optional idle cycles, then hold start until the edge that takes it
	task automatic issue(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		value <= v;
		position <= pos;
		// busy sampled before the edge updates it
		do @(posedge clk); while (busy);
	endtask

	// stop sending until every expected beat is in, then let the block settle
	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [OP_W-1:0] pick_op(input burst_mode_t mode);
		int r, ins_band;
		case (mode)
			GROW:    ins_band = 85;
			SHRINK:  ins_band = 20;
			default: ins_band = 45;
		endcase
		r = $urandom_range(99);
		if (r < ins_band) begin
			case ($urandom_range(2))
				0:       return OP_INS_HEAD;
				1:       return OP_INS_TAIL;
				default: return OP_INS_AFTER;
			endcase
		end
		r = $urandom_range(99);
		if (r < 26) return OP_DEL_HEAD;
		if (r < 52) return OP_DEL_TAIL;
		if (r < 80) return OP_DEL_AT;
		if (r < 97) return OP_DISPLAY;
		return OP_UNUSED;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value;
		case ($urandom_range(19))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// mostly around the live range of positions, now and then anywhere
	function automatic logic [POS_W-1:0] pick_position;
		if ($urandom_range(99) < 85) return POS_W'($urandom_range(CAPACITY + 2));
		return POS_W'($urandom_range(63));
	endfunction

	initial begin
		int sent;
		int burst_len;
		burst_mode_t mode;
		logic [OP_W-1:0] op;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners, sender idles lightly
		idle_pct = 8;
		issue(OP_DISPLAY, '0, '0);              // display of empty list
		issue(OP_DEL_HEAD, '0, '0);             // delete head when empty
		issue(OP_DEL_TAIL, '0, '0);             // delete tail when empty
		issue(OP_DEL_AT, '0, 6'd1);             // positional delete on empty list
		issue(OP_INS_AFTER, 32'sd5, 6'd1);      // positional insert on empty list
		issue(OP_INS_HEAD, 32'sh7fffffff, '0);
		issue(OP_INS_TAIL, 32'sh80000000, 6'd63);
		issue(OP_INS_AFTER, 32'sd9, 6'd0);      // position zero
		issue(OP_INS_AFTER, 32'sd9, 6'd3);      // one past the end
		issue(OP_INS_AFTER, -32'sd1, 6'd2);     // after the tail
		issue(OP_INS_AFTER, '0, 6'd1);          // in the middle
		issue(OP_DISPLAY, '1, '1);
		issue(OP_DEL_AT, '0, 6'd0);
		issue(OP_DEL_AT, '0, 6'd63);
		issue(OP_DEL_AT, '0, 6'd2);             // middle node
		issue(OP_DEL_AT, '0, 6'd3);             // tail node by position
		issue(OP_DISPLAY, '0, '0);
		issue(OP_UNUSED, 32'sh5a5a5a5a, 6'd63); // ignored opcode
		issue(OP_DEL_HEAD, '0, '0);
		issue(OP_DEL_TAIL, '0, '0);
		issue(OP_DISPLAY, '0, '0);
		drain();

		// random bursts, three idle profiles for the sender
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       idle_pct = 8;
				1:       idle_pct = 68;
				default: idle_pct = 0;
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				// each phase opens with a long grow burst so the list gets to full
				if (sent == 0) begin
					mode = GROW;
					burst_len = 45;
				end else begin
					mode = burst_mode_t'($urandom_range(2));
					burst_len = $urandom_range(15, 45);
				end
				for (int i = 0; i < burst_len && sent < ITEMS_PER_PHASE; i++) begin
					op = pick_op(mode);
					issue(op, pick_value(), pick_position());
					if (op != OP_UNUSED) sent++;
				end
				// hold-off in the middle of a phase
				if (sent >= ITEMS_PER_PHASE / 2 && sent < ITEMS_PER_PHASE / 2 + burst_len)
					drain();
			end
			drain();
		end

		$display("covered %0d accepted commands and %0d result beats under light, heavy and no sender idling",
			cmds_seen, beats_seen);
		$display("directed corners first, then grow, shrink and mixed bursts with drain pauses");
		if (fail_count == 0) begin
			$display("doubly_linked_list_engine_core regression: pass");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("doubly_linked_list_engine_core regression: fail");
		end
		$finish;
	end

endmodule
